// ----- rtl/ins_pkg.sv -----
// ----------------------------------------------------------------------------
// ins_pkg
// types and constants shared by the integer newton square root modules
// ----------------------------------------------------------------------------
`default_nettype none

package ins_pkg;

    localparam int ITER_WIDTH = 8;
    localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic update;
        logic set_conv;
    } cmd_t;

    typedef struct packed {
        logic negative;
        logic zero;
        logic limit;
        logic div_busy;
        logic next_equal;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/integer_newton_square_root.sv -----
// ----------------------------------------------------------------------------
// integer_newton_square_root
// integer square root by truncating newton iteration, estimate starts at
// the radicand, stops on a repeated estimate or at max_iterations
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result is on the output ports for the
// single cycle in which done is high and cannot be held off, so the receiver
// must take it then. Each newton iteration runs one division on a shared
// restoring divider that yields one quotient bit per cycle, so an iteration
// passes through check, the divide steps plus the state that sees the divider
// finish, and update. max_iterations may be written only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_newton_square_root #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [DATA_WIDTH-1:0]    radicand,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ins_pkg::ITER_WIDTH-1:0]  cfg_wr_data,
    output logic                                 done,
    output logic [DATA_WIDTH-2:0]                root,
    output logic [ins_pkg::ITER_WIDTH-1:0]       iterations_done,
    output logic                                 converged,
    output logic                                 negative_error
);

    ins_pkg::cmd_t    cmd;
    ins_pkg::status_t status;

    ins_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ins_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .radicand        (radicand),
        .root            (root),
        .iterations_done (iterations_done),
        .converged       (converged),
        .negative_error  (negative_error)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done held for more than one cycle");

    a_negative_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && negative_error) |-> (root == '0 && iterations_done == '0 && !converged))
        else $error("negative radicand gave a nonzero result");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a busy period");

endmodule

`default_nettype wire

// ----- rtl/ins_divider.sv -----
// ----------------------------------------------------------------------------
// ins_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ins_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       div_busy,
    output logic [DATA_WIDTH-1:0]      quotient
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] quo_next;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff     = shifted - {1'b0, divisor};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CW'(DATA_WIDTH);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[DATA_WIDTH])
            begin
                rem_next = diff[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign div_busy = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/ins_datapath.sv -----
// ----------------------------------------------------------------------------
// ins_datapath
// estimate, radicand, iteration count and limit registers with the divider
// ----------------------------------------------------------------------------
`default_nettype none

module ins_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ins_pkg::cmd_t                       cmd,
    output ins_pkg::status_t                         status,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ins_pkg::ITER_WIDTH-1:0]      cfg_wr_data,
    input  wire logic signed [DATA_WIDTH-1:0]        radicand,
    output logic [DATA_WIDTH-2:0]                    root,
    output logic [ins_pkg::ITER_WIDTH-1:0]           iterations_done,
    output logic                                     converged,
    output logic                                     negative_error
);

    logic [ins_pkg::ITER_WIDTH-1:0] max_iter_reg;
    logic [DATA_WIDTH-1:0]          n_reg;
    logic [DATA_WIDTH-1:0]          est_reg;
    logic [ins_pkg::ITER_WIDTH-1:0] count_reg;
    logic                           conv_reg;
    logic [DATA_WIDTH-1:0]          quotient;
    logic                           div_busy;
    logic [DATA_WIDTH:0]            sum;
    logic [DATA_WIDTH-1:0]          est_next;

    ins_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (est_reg),
        .div_busy (div_busy),
        .quotient (quotient)
    );

    assign sum      = {1'b0, est_reg} + {1'b0, quotient};
    assign est_next = sum[DATA_WIDTH:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= ins_pkg::MAX_ITER_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_iter_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg     <= radicand;
            est_reg   <= radicand;
            count_reg <= '0;
            conv_reg  <= (radicand == '0);
        end
        else
        begin
            if (cmd.update)
            begin
                est_reg   <= est_next;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.set_conv)
            begin
                conv_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        status.negative   = n_reg[DATA_WIDTH-1];
        status.zero       = (n_reg == '0);
        status.limit      = (count_reg == max_iter_reg);
        status.div_busy   = div_busy;
        status.next_equal = (est_next == est_reg);
    end

    assign negative_error  = n_reg[DATA_WIDTH-1];
    assign root            = n_reg[DATA_WIDTH-1] ? '0 : est_reg[DATA_WIDTH-2:0];
    assign iterations_done = count_reg;
    assign converged       = conv_reg;

endmodule

`default_nettype wire

// ----- rtl/ins_ctrl.sv -----
// ----------------------------------------------------------------------------
// ins_ctrl
// sequencer for the newton iteration: check, divide, update
// ----------------------------------------------------------------------------
`default_nettype none

module ins_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire ins_pkg::status_t status,
    output ins_pkg::cmd_t         cmd,
    output logic                  busy,
    output logic                  done
);

    ins_pkg::state_t state_reg;
    ins_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ins_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ins_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ins_pkg::ST_CHECK;
                end
            end
            ins_pkg::ST_CHECK:
            begin
                if (status.negative || status.zero || status.limit)
                begin
                    state_next = ins_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = ins_pkg::ST_DIV;
                end
            end
            ins_pkg::ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ins_pkg::ST_UPDATE;
                end
            end
            ins_pkg::ST_UPDATE:
            begin
                if (status.next_equal)
                begin
                    state_next = ins_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = ins_pkg::ST_CHECK;
                end
            end
            ins_pkg::ST_FINISH:
            begin
                state_next = ins_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ins_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ins_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ins_pkg::ST_CHECK:
            begin
                cmd.div_start = !(status.negative || status.zero || status.limit);
            end
            ins_pkg::ST_DIV:
            begin
            end
            ins_pkg::ST_UPDATE:
            begin
                cmd.update   = !status.next_equal;
                cmd.set_conv = status.next_equal;
            end
            ins_pkg::ST_FINISH:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/integer_newton_square_root_tb.sv -----
// ----------------------------------------------------------------------------
// integer_newton_square_root_tb
// self-checking bench for the newton square root block: a scoreboard predicts
// root, iteration count and flags for each accepted item from the iteration
// limit in force, directed corner and limit items come first, then random
// phases under several limits with random or no sender gaps
// ----------------------------------------------------------------------------

module integer_newton_square_root_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH   = 32;
    localparam int ITEMS_PER_PH = 41;
    localparam int QUIET_LIMIT  = 30000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed {
        logic [DATA_WIDTH-2:0]          root;
        logic [ins_pkg::ITER_WIDTH-1:0] iterations;
        logic                           converged;
        logic                           negative;
    } sqrt_outcome_t;

    class root_scoreboard;
        logic [ins_pkg::ITER_WIDTH-1:0] iteration_limit;
        sqrt_outcome_t                  pending_roots[$];
        int                             mismatches;

        function new();
            iteration_limit = ins_pkg::MAX_ITER_RESET;
            mismatches      = 0;
        endfunction

        function int outstanding();
            return pending_roots.size();
        endfunction

        function sqrt_outcome_t predict_root(logic signed [DATA_WIDTH-1:0] value);
            sqrt_outcome_t                  outcome;
            logic [DATA_WIDTH-1:0]          n;
            logic [DATA_WIDTH-1:0]          estimate;
            logic [DATA_WIDTH-1:0]          quotient;
            logic [DATA_WIDTH:0]            total;
            logic [ins_pkg::ITER_WIDTH-1:0] count;
            outcome = '0;
            n       = value;
            if (value < 0)
            begin
                outcome.negative = 1'b1;
                return outcome;
            end
            if (n == '0)
            begin
                outcome.converged = 1'b1;
                return outcome;
            end
            estimate = n;
            count    = '0;
            while (count < iteration_limit)
            begin
                quotient = (estimate != '0) ? n / estimate : '0;
                total    = {1'b0, estimate} + {1'b0, quotient};
                if (total[DATA_WIDTH:1] == estimate)
                begin
                    outcome.converged = 1'b1;
                    break;
                end
                estimate = total[DATA_WIDTH:1];
                count    = count + 1'b1;
            end
            outcome.root       = estimate[DATA_WIDTH-2:0];
            outcome.iterations = count;
            return outcome;
        endfunction

        function void note_radicand(logic signed [DATA_WIDTH-1:0] value);
            pending_roots.push_back(predict_root(value));
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            mismatches++;
            $display("%0t ns: mismatch on %s: got %0d expected %0d", $realtime, what, got,
                     want);
        endtask

        task check_result(logic [DATA_WIDTH-2:0] root, logic [ins_pkg::ITER_WIDTH-1:0] iters,
                          logic conv, logic neg);
            sqrt_outcome_t want;
            if (pending_roots.size() == 0)
            begin
                report_mismatch("unexpected result, root", root, 0);
                return;
            end
            want = pending_roots.pop_front();
            if (root !== want.root)
                report_mismatch("root", root, want.root);
            if (iters !== want.iterations)
                report_mismatch("iterations_done", iters, want.iterations);
            if (conv !== want.converged)
                report_mismatch("converged", conv, want.converged);
            if (neg !== want.negative)
                report_mismatch("negative_error", neg, want.negative);
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic signed [DATA_WIDTH-1:0]   radicand;
    logic                           cfg_wr_en;
    logic [ins_pkg::ITER_WIDTH-1:0] cfg_wr_data;
    logic                           done;
    logic [DATA_WIDTH-2:0]          root;
    logic [ins_pkg::ITER_WIDTH-1:0] iterations_done;
    logic                           converged;
    logic                           negative_error;

    root_scoreboard board;
    int             quiet_cycles;

    integer_newton_square_root #(
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .radicand(radicand),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done(done),
        .root(root),
        .iterations_done(iterations_done),
        .converged(converged),
        .negative_error(negative_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(root, iterations_done, converged, negative_error);
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("integer_newton_square_root verification failed");
                $finish;
            end
        end
    end

    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function logic signed [DATA_WIDTH-1:0] pick_radicand();
        logic [DATA_WIDTH-1:0] bits;
        int                    k;
        bits = $urandom;
        k    = $urandom_range(1, 46340);
        case ($urandom_range(0, 9))
            0, 1, 2: return bits;
            3:       return {1'b1, bits[DATA_WIDTH-2:0]};
            4, 5:    return $urandom_range(0, 300);
            6:       return k * k;
            7:       return k * k - 1;
            8:       return k * k + 1;
            default:
            begin
                case ($urandom_range(0, 7))
                    0:       return 32'h7fffffff;
                    1:       return 32'h7ffffffe;
                    2:       return 32'h80000000;
                    3:       return 32'hffffffff;
                    4:       return 32'h40000000;
                    5:       return 3;
                    6:       return 2;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    task send_item(logic signed [DATA_WIDTH-1:0] value, int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start    <= 1'b0;
            radicand <= $urandom;
        end
        @(negedge clk);
        start    <= 1'b1;
        radicand <= value;
        do
            @(posedge clk);
        while (busy);
        board.note_radicand(value);
    endtask

    task wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (board.outstanding() != 0 || busy)
            @(negedge clk);
    endtask

    task write_limit(logic [ins_pkg::ITER_WIDTH-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= $urandom;
        board.iteration_limit = value;
    endtask

    initial
    begin
        logic [ins_pkg::ITER_WIDTH-1:0] phase_limits[6];
        logic signed [DATA_WIDTH-1:0]   corner_items[16];
        bit                             no_idle;

        start        = 1'b0;
        radicand     = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        rst_n        = 1'b0;
        quiet_cycles = 0;
        board        = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // corner items under the reset limit
        corner_items = '{0, 1, 2, 3, 4, 15, 16, 65535, 65536, 32'h7fffffff, 32'h7ffffffe,
                         32'h40000000, 32'h55555555, 32'h80000000, 32'hffffffff,
                         32'haaaaaaaa};
        foreach (corner_items[i])
            send_item(corner_items[i], pick_gap());

        // oscillating estimates run to the widest limit
        write_limit(8'd255);
        send_item(3, 0);
        send_item(2147395599, pick_gap());
        send_item(32'h7fffffff, 0);

        // zero limit returns a nonnegative radicand itself
        write_limit(8'd0);
        send_item(0, 0);
        send_item(32'h7fffffff, 1);
        send_item(5, 0);
        send_item(32'h80000000, 2);

        write_limit(8'd1);
        send_item(32'h7fffffff, 0);
        send_item(1, 0);

        phase_limits = '{8'd255, 8'd1, 8'($urandom_range(2, 12)), 8'd0,
                         8'($urandom_range(13, 254)), ins_pkg::MAX_ITER_RESET};
        foreach (phase_limits[p])
        begin
            write_limit(phase_limits[p]);
            no_idle = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < ITEMS_PER_PH; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
                send_item(pick_radicand(), no_idle ? 0 : pick_gap());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("integer_newton_square_root verification clean");
        else
            $display("integer_newton_square_root verification failed");
        $finish;
    end

endmodule
